// ===== src/isd_pkg.sv =====
// isd_pkg: shared types, codes and constants for the indexed stack deque.
// Used by isd_ctrl, isd_datapath and indexed_stack_deque. No dependencies.
package isd_pkg;

    // Storage geometry; DEPTH must be a power of two
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int DATA_W = 32;

    // Field widths of the channels
    localparam int CMD_W  = 3;
    localparam int POS_W  = 6;
    localparam int STAT_W = 2;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_READ       = 3'd3,
        CMD_UPDATE     = 3'd4,
        CMD_INSERT     = 3'd5,
        CMD_REVERSE    = 3'd6,
        CMD_CLEAR      = 3'd7
    } cmd_t;

    // Status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Strobes from the controller to the datapath
    typedef struct packed {
        logic load;        // capture the incoming word
        logic exec;        // apply the command
        logic rd_cap;      // capture read data for a read command
        logic shift_rd;    // fetch the entry below the shift cursor
        logic shift_wr;    // move fetched entry up one slot
        logic shift_last;  // write the inserted value
        logic top_rd;      // fetch front entry
        logic bot_rd;      // capture front, fetch back entry
        logic done_cap;    // load the output word
    } dp_ctrl_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_read;   // read command will return a value
        logic need_shift;  // insert command will be carried out
        logic shift_more;  // entries remain to be moved
    } dp_stat_t;

    // Physical slot of a logical index
    function automatic logic [ADDR_W-1:0] slot_of(
        input logic [ADDR_W-1:0] front,
        input logic              rev,
        input logic [ADDR_W-1:0] logical
    );
        slot_of = rev ? (front - logical) : (front + logical);
    endfunction

endpackage

// ===== src/isd_ctrl.sv =====
// isd_ctrl: sequencing state machine for the indexed stack deque.
// Depends on isd_pkg; drives isd_datapath through dp_ctrl_t strobes.
module isd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    input  isd_pkg::dp_stat_t stat,
    output isd_pkg::dp_ctrl_t ctrl
);
    import isd_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EXEC  = 8'b0000_0010,
        S_RDCAP = 8'b0000_0100,
        S_SHRD  = 8'b0000_1000,
        S_SHWR  = 8'b0001_0000,
        S_TOP   = 8'b0010_0000,
        S_BOT   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    // Output word slot is free when empty or being taken this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // Next state and strobes
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctrl.exec = 1'b1;
                if (stat.need_read)
                    state_next = S_RDCAP;
                else if (stat.need_shift)
                    state_next = S_SHRD;
                else
                    state_next = S_TOP;
            end
            S_RDCAP:
            begin
                ctrl.rd_cap = 1'b1;
                state_next  = S_TOP;
            end
            S_SHRD:
            begin
                if (stat.shift_more)
                begin
                    ctrl.shift_rd = 1'b1;
                    state_next    = S_SHWR;
                end
                else
                begin
                    ctrl.shift_last = 1'b1;
                    state_next      = S_TOP;
                end
            end
            S_SHWR:
            begin
                ctrl.shift_wr = 1'b1;
                state_next    = S_SHRD;
            end
            S_TOP:
            begin
                ctrl.top_rd = 1'b1;
                state_next  = S_BOT;
            end
            S_BOT:
            begin
                ctrl.bot_rd = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ctrl.done_cap = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on a new word, held while stalled
    always_comb
    begin
        if (ctrl.done_cap)
            rsp_valid_next = 1'b1;
        else
            rsp_valid_next = rsp_valid_reg && rsp_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== src/isd_datapath.sv =====
// isd_datapath: element memory, ring pointers and output word registers.
// Depends on isd_pkg; sequenced by isd_ctrl.
module isd_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  isd_pkg::dp_ctrl_t                 ctrl,
    output isd_pkg::dp_stat_t                 stat,
    input  logic [isd_pkg::CMD_W-1:0]         command,
    input  logic [isd_pkg::POS_W-1:0]         position,
    input  logic signed [isd_pkg::DATA_W-1:0] data_in,
    output logic [isd_pkg::STAT_W-1:0]        status,
    output logic signed [isd_pkg::DATA_W-1:0] read_value,
    output logic signed [isd_pkg::DATA_W-1:0] top_value,
    output logic signed [isd_pkg::DATA_W-1:0] bottom_value,
    output logic [isd_pkg::CNT_W-1:0]         count,
    output logic                              is_empty
);
    import isd_pkg::*;

    // Element memory, one write and one registered read per cycle
    logic [DATA_W-1:0] mem [DEPTH];

    // Control state
    logic [ADDR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rev_reg, rev_next;

    // Captured word and working registers
    cmd_t              cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] data_reg;
    logic [CNT_W-1:0]  k_reg, k_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] rd_reg, top_reg, rdata_reg;

    // Output word registers
    logic [STAT_W-1:0] out_status_reg;
    logic [DATA_W-1:0] out_read_reg, out_top_reg, out_bot_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_empty_reg;

    // Memory port controls
    logic              we, re;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [DATA_W-1:0] wdata;

    // Derived conditions
    logic              empty, full, pos_oob, idx_ok;
    logic [CNT_W-1:0]  pos_ext, pos_p1, k_m1, cnt_m1;

    assign pos_ext = {1'b0, pos_reg};
    assign pos_p1  = pos_ext + CNT_W'(1);
    assign k_m1    = k_reg - CNT_W'(1);
    assign cnt_m1  = count_reg - CNT_W'(1);
    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign pos_oob = (pos_ext >= count_reg);
    assign idx_ok  = !empty && !pos_oob;

    assign stat.need_read  = (cmd_reg == CMD_READ) && idx_ok;
    assign stat.need_shift = (cmd_reg == CMD_INSERT) && idx_ok && !full;
    assign stat.shift_more = (k_reg > pos_p1);

    // Command execution and memory port selection
    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        k_next      = k_reg;
        status_next = status_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = data_reg;
        re          = 1'b0;
        raddr       = '0;

        if (ctrl.exec)
        begin
            status_next = ST_OK;
            case (cmd_reg)
                CMD_PUSH_FRONT:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        front_next = rev_reg ? front_reg + ADDR_W'(1)
                                             : front_reg - ADDR_W'(1);
                        we         = 1'b1;
                        waddr      = front_next;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        we         = 1'b1;
                        waddr      = slot_of(front_reg, rev_reg, count_reg[ADDR_W-1:0]);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        front_next = slot_of(front_reg, rev_reg, ADDR_W'(1));
                        count_next = cnt_m1;
                    end
                end
                CMD_READ, CMD_UPDATE, CMD_INSERT:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else if (pos_oob)
                        status_next = ST_RANGE;
                    else if (cmd_reg == CMD_READ)
                    begin
                        re    = 1'b1;
                        raddr = slot_of(front_reg, rev_reg, pos_reg);
                    end
                    else if (cmd_reg == CMD_UPDATE)
                    begin
                        we    = 1'b1;
                        waddr = slot_of(front_reg, rev_reg, pos_reg);
                    end
                    else if (full)
                        status_next = ST_FULL;
                    else
                        k_next = count_reg;
                end
                CMD_REVERSE:
                begin
                    if (!empty)
                        front_next = slot_of(front_reg, rev_reg, cnt_m1[ADDR_W-1:0]);
                    rev_next = !rev_reg;
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                    front_next = '0;
                    rev_next   = 1'b0;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
        else if (ctrl.shift_rd)
        begin
            re    = 1'b1;
            raddr = slot_of(front_reg, rev_reg, k_m1[ADDR_W-1:0]);
        end
        else if (ctrl.shift_wr)
        begin
            we     = 1'b1;
            waddr  = slot_of(front_reg, rev_reg, k_reg[ADDR_W-1:0]);
            wdata  = rdata_reg;
            k_next = k_m1;
        end
        else if (ctrl.shift_last)
        begin
            we         = 1'b1;
            waddr      = slot_of(front_reg, rev_reg, pos_p1[ADDR_W-1:0]);
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.top_rd)
        begin
            re    = 1'b1;
            raddr = front_reg;
        end
        else if (ctrl.bot_rd)
        begin
            re    = 1'b1;
            raddr = slot_of(front_reg, rev_reg, cnt_m1[ADDR_W-1:0]);
        end
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    // Pointer, count and direction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        status_reg <= status_next;
        if (ctrl.load)
        begin
            cmd_reg  <= cmd_t'(command);
            pos_reg  <= position;
            data_reg <= data_in;
        end
        if (ctrl.exec)
            rd_reg <= '0;
        else if (ctrl.rd_cap)
            rd_reg <= rdata_reg;
        if (ctrl.bot_rd)
            top_reg <= rdata_reg;
        if (ctrl.done_cap)
        begin
            out_status_reg <= status_reg;
            out_read_reg   <= rd_reg;
            out_top_reg    <= empty ? '0 : top_reg;
            out_bot_reg    <= empty ? '0 : rdata_reg;
            out_count_reg  <= count_reg;
            out_empty_reg  <= empty;
        end
    end

    assign status       = out_status_reg;
    assign read_value   = out_read_reg;
    assign top_value    = out_top_reg;
    assign bottom_value = out_bot_reg;
    assign count        = out_count_reg;
    assign is_empty     = out_empty_reg;

endmodule

// ===== src/indexed_stack_deque.sv =====
// indexed_stack_deque: bounded deque/stack of signed words in a ring memory.
// Depends on isd_pkg, isd_ctrl and isd_datapath.
//
//  channel | handshake            | fields
//  --------+----------------------+---------------------------------------------
//  cmd     | cmd_valid, cmd_stall | command, position, data_in
//  rsp     | rsp_valid, rsp_stall | status, read_value, top_value,
//          |                      | bottom_value, count, is_empty
//
// One word at a time: each accepted command is executed; a read then captures its
// value, an insert after a position moves each later entry up with a read and then
// a write of the element memory, and the front and back entries are fetched last.
// Reset clears pointer, count and direction; memory contents are not cleared.
// A stalled result is held in the output register; the next word is accepted
// meanwhile and waits for the output register before completing.
module indexed_stack_deque (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [isd_pkg::CMD_W-1:0]         command,
    input  logic [isd_pkg::POS_W-1:0]         position,
    input  logic signed [isd_pkg::DATA_W-1:0] data_in,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [isd_pkg::STAT_W-1:0]        status,
    output logic signed [isd_pkg::DATA_W-1:0] read_value,
    output logic signed [isd_pkg::DATA_W-1:0] top_value,
    output logic signed [isd_pkg::DATA_W-1:0] bottom_value,
    output logic [isd_pkg::CNT_W-1:0]         count,
    output logic                              is_empty
);
    import isd_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    // Sequencer
    isd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // Storage and arithmetic
    isd_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .command      (command),
        .position     (position),
        .data_in      (data_in),
        .status       (status),
        .read_value   (read_value),
        .top_value    (top_value),
        .bottom_value (bottom_value),
        .count        (count),
        .is_empty     (is_empty)
    );

endmodule
